### rtl/core/gvb_pkg.sv
// ----------------------------------------------------------------------------
// gvb_pkg
// Constants and shared types for the genotype vector binning block.
// ----------------------------------------------------------------------------
package gvb_pkg;

   localparam int MAX_BINS        = 64;
   localparam int MAX_INDIVIDUALS = 256;
   localparam int GENO_BITS       = 4;

   localparam int GENO_W = 4;
   localparam int BIN_W  = $clog2(MAX_BINS + 1);
   localparam int POS_W  = $clog2(MAX_INDIVIDUALS + 1);
   localparam int ADDR_W = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;

   // broadcast control from the sequencer to every bin cell
   typedef struct packed {
      logic                 rd_en;
      logic                 wr_ok;
      logic [ADDR_W-1:0]    addr;
      logic [GENO_BITS-1:0] wr_geno;
      logic                 clear;
      logic                 cmp_en;
      logic [GENO_BITS-1:0] cmp_geno;
      logic                 exact;
      logic                 load;
      logic                 shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_SRCH = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

endpackage

### rtl/core/gvb_if.sv
// ----------------------------------------------------------------------------
// gvb_if
// Channel interfaces: request word, response word and register write.
// ----------------------------------------------------------------------------
interface gvb_req_if;
   logic                valid;
   logic                ready;
   logic [3:0]          genotype;
   logic                last_of_marker;
   logic                first_of_dataset;
   modport source (output valid, genotype, last_of_marker, first_of_dataset, input ready);
   modport sink   (input valid, genotype, last_of_marker, first_of_dataset, output ready);
endinterface

interface gvb_rsp_if;
   logic                valid;
   logic                ready;
   logic [gvb_pkg::BIN_W-1:0] bin_number;
   logic                opened_new_bin;
   logic                table_overflow;
   modport source (output valid, bin_number, opened_new_bin, table_overflow, input ready);
   modport sink   (input valid, bin_number, opened_new_bin, table_overflow, output ready);
endinterface

interface gvb_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/core/gvb_cell.sv
// ----------------------------------------------------------------------------
// gvb_cell
// One bin: representative vector memory, mismatch flag and a search-chain bit.
// ----------------------------------------------------------------------------
module gvb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  gvb_pkg::cell_ctrl_type ctrl,
   input  logic                   wr_en,
   input  logic                   in_use,
   input  logic                   match_in,
   output logic                   match_out
);
   import gvb_pkg::*;

   logic [GENO_BITS-1:0] mem [MAX_INDIVIDUALS];
   logic [GENO_BITS-1:0] rd_ff;
   logic                 mism_ff, mism_in;
   logic                 mbit_ff, mbit_in;
   logic                 differ;

   always_ff @(posedge clock) begin
      if (wr_en && ctrl.wr_ok) begin
         mem[ctrl.addr] <= ctrl.wr_geno;
      end
      if (ctrl.rd_en) begin
         rd_ff <= mem[ctrl.addr];
      end
   end

   always_comb begin
      differ = (ctrl.cmp_geno != rd_ff) &&
               (ctrl.exact || ((ctrl.cmp_geno != '0) && (rd_ff != '0)));
      mism_in = mism_ff;
      if (ctrl.cmp_en && in_use && differ) begin
         mism_in = 1'b1;
      end
      if (ctrl.clear) begin
         mism_in = 1'b0;
      end
      mbit_in = mbit_ff;
      if (ctrl.load) begin
         mbit_in = in_use && !mism_in;
      end else if (ctrl.shift) begin
         mbit_in = match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mism_ff <= 1'b0;
         mbit_ff <= 1'b0;
      end else begin
         mism_ff <= mism_in;
         mbit_ff <= mbit_in;
      end
   end

   assign match_out = mbit_ff;

endmodule

### rtl/core/genotype_vector_binning.sv
// ----------------------------------------------------------------------------
// genotype_vector_binning
// Bins markers by their genotype vectors against a row of bin cells.
// ----------------------------------------------------------------------------
// req: one genotype word per individual; last_of_marker closes the marker,
//   first_of_dataset empties the bin table before the word is handled.
// rsp: one word per closed marker: bin number (from 1, 0 on overflow),
//   new-bin flag and overflow flag.
// csr: single-bit exact_mode write; user writes only while idle, not enforced.
// Each bin cell holds its representative in a local memory; the next free
// cell takes the streaming marker so a new bin needs no copy.
// Each word is handled as a memory read, then a compare in all cells at once.
// A closing word adds the search: the match bits shift through the cell
// chain one bin per cycle, newest first, and then the response is issued.
// No new word is taken before the last one is through these steps.
// The response sits in an output register; if the receiver stalls, further
// non-closing words are still taken and the next closing word waits.
// Reset empties the table, clears the mismatch flags and sets exact_mode to 1;
// the representative memories are not cleared.
// ----------------------------------------------------------------------------
module genotype_vector_binning (
   input  logic      clock,
   input  logic      reset,
   gvb_req_if.sink   req_if,
   gvb_rsp_if.source rsp_if,
   gvb_csr_if.sink   csr_if
);
   import gvb_pkg::*;

   state_type            state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [BIN_W-1:0]     bins_ff, bins_in;
   logic [BIN_W-1:0]     idx_ff, idx_in;
   logic [BIN_W-1:0]     fbin_ff, fbin_in;
   logic                 found_ff, found_in;
   logic                 exact_ff;
   logic [GENO_BITS-1:0] geno_ff;
   logic                 last_ff;
   logic                 posok_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]     rsp_bin_ff, rsp_bin_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 accept;
   logic [POS_W-1:0]     eff_pos;
   logic [BIN_W-1:0]     eff_bins;
   logic                 pos_ok;
   logic                 out_free;
   cell_ctrl_type        ctrl;
   logic [MAX_BINS-1:0]  wr_en, in_use;
   logic [MAX_BINS:0]    chain;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign eff_pos  = req_if.first_of_dataset ? '0 : pos_ff;
   assign eff_bins = req_if.first_of_dataset ? '0 : bins_ff;
   assign pos_ok   = (eff_pos < POS_W'(MAX_INDIVIDUALS));

   always_comb begin
      ctrl.rd_en    = accept;
      ctrl.wr_ok    = accept && pos_ok;
      ctrl.addr     = eff_pos[ADDR_W-1:0];
      ctrl.wr_geno  = req_if.genotype[GENO_BITS-1:0];
      ctrl.clear    = (accept && req_if.first_of_dataset) || ((state_ff == S_OUT) && out_free);
      ctrl.cmp_en   = (state_ff == S_CMP) && posok_ff;
      ctrl.cmp_geno = geno_ff;
      ctrl.exact    = exact_ff;
      ctrl.load     = (state_ff == S_CMP) && last_ff;
      ctrl.shift    = (state_ff == S_SRCH);
   end

   assign chain[0] = 1'b0;

   for (genvar b = 0; b < MAX_BINS; b++) begin : g_cell
      assign wr_en[b]  = (eff_bins == BIN_W'(b));
      assign in_use[b] = (BIN_W'(b) < bins_ff);
      gvb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .wr_en     (wr_en[b]),
         .in_use    (in_use[b]),
         .match_in  (chain[b]),
         .match_out (chain[b+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      bins_in      = bins_ff;
      idx_in       = idx_ff;
      fbin_in      = fbin_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_bin_in   = rsp_bin_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               bins_in  = eff_bins;
               pos_in   = pos_ok ? eff_pos + POS_W'(1) : eff_pos;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (last_ff) begin
               idx_in   = BIN_W'(MAX_BINS);
               state_in = S_SRCH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SRCH: begin
            // top of the chain holds the match bit of bin idx
            if (chain[MAX_BINS]) begin
               fbin_in  = idx_ff;
               found_in = 1'b1;
               state_in = S_OUT;
            end else if (idx_ff == BIN_W'(1)) begin
               found_in = 1'b0;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff - BIN_W'(1);
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_new_in   = 1'b0;
               rsp_ovf_in   = 1'b0;
               if (found_ff) begin
                  rsp_bin_in = fbin_ff;
               end else if (bins_ff < BIN_W'(MAX_BINS)) begin
                  rsp_bin_in = bins_ff + BIN_W'(1);
                  bins_in    = bins_ff + BIN_W'(1);
                  rsp_new_in = 1'b1;
               end else begin
                  rsp_bin_in = '0;
                  rsp_ovf_in = 1'b1;
               end
               pos_in   = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         bins_ff      <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         exact_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bins_ff      <= bins_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            exact_ff <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      fbin_ff    <= fbin_in;
      rsp_bin_ff <= rsp_bin_in;
      rsp_new_ff <= rsp_new_in;
      rsp_ovf_ff <= rsp_ovf_in;
      if (accept) begin
         geno_ff  <= req_if.genotype[GENO_BITS-1:0];
         last_ff  <= req_if.last_of_marker;
         posok_ff <= pos_ok;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.bin_number     = rsp_bin_ff;
   assign rsp_if.opened_new_bin = rsp_new_ff;
   assign rsp_if.table_overflow = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   a_bins_bound: assert property (@(posedge clock) disable iff (reset)
      bins_ff <= BIN_W'(MAX_BINS))
      else $error("bin count beyond table size");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_ovf_ff))
      else $error("new bin and overflow together");

   a_ovf_bin0: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_bin_ff == '0))
      else $error("overflow word with non-zero bin");

   a_new_bin: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && out_free && !found_ff && (bins_ff < BIN_W'(MAX_BINS)))
      |=> (bins_ff == $past(bins_ff) + BIN_W'(1)) && (rsp_bin_ff == bins_ff))
      else $error("new bin number does not follow bin count");
`endif

endmodule

### tb/sv/tb_genotype_vector_binning.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_genotype_vector_binning
// Self-checking bench: a directed table, then overflow and over-long markers,
// then random datasets of markers. Each response word is checked against the
// table's value or a bin-table predictor kept in step with accepted words.
// ----------------------------------------------------------------------------
module tb_genotype_vector_binning;
   import gvb_pkg::*;

   localparam int CLK_HALF   = 6;
   localparam int DRAIN      = 2 * MAX_BINS + 20;
   localparam int CYCLE_CAP  = 1000000;
   localparam int RAND_WORDS = 330;

   typedef struct packed {
      logic [BIN_W-1:0] bin_number;
      logic             opened_new_bin;
      logic             table_overflow;
   } bin_rsp_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [3:0]   geno;
      bit           last;
      bit           first;
      bit           known;
      bin_rsp_type  rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   gvb_req_if req ();
   gvb_rsp_if rsp ();
   gvb_csr_if csr ();

   genotype_vector_binning dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   // predictor state
   logic [GENO_BITS-1:0] rep_store [MAX_BINS][MAX_INDIVIDUALS];
   logic [GENO_BITS-1:0] marker_words [MAX_INDIVIDUALS];
   bit                   bin_differs [MAX_BINS];
   int unsigned          geno_pos;
   int unsigned          bins_used;
   bit                   exact_cfg;

   bin_rsp_type bin_q [$];
   int          errors;
   int          cycles;
   bit          hold_rsp;
   bit          hold_go;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // works out the response, if any, of one accepted request word
   task automatic bin_word(input logic [3:0] g_in, input bit l, input bit f,
                           output bit has_rsp, output bin_rsp_type r);
      logic [GENO_BITS-1:0] g;
      logic [GENO_BITS-1:0] rg;
      bit found;
      g = g_in[GENO_BITS-1:0];
      has_rsp = 1'b0;
      r = '0;
      found = 1'b0;
      if (f) begin
         bins_used = 0;
         foreach (bin_differs[b]) bin_differs[b] = 1'b0;
         geno_pos = 0;
      end
      if (geno_pos < MAX_INDIVIDUALS) begin
         marker_words[geno_pos] = g;
         for (int b = 0; b < bins_used; b++) begin
            rg = rep_store[b][geno_pos];
            if (g != rg && (exact_cfg || (g != 0 && rg != 0)))
               bin_differs[b] = 1'b1;
         end
         geno_pos++;
      end
      if (l) begin
         has_rsp = 1'b1;
         for (int b = bins_used; b > 0; b--) begin
            if (!found && !bin_differs[b-1]) begin
               r.bin_number = b[BIN_W-1:0];
               found = 1'b1;
            end
         end
         if (!found) begin
            if (bins_used < MAX_BINS) begin
               for (int p = 0; p < geno_pos; p++)
                  rep_store[bins_used][p] = marker_words[p];
               bins_used++;
               r.bin_number = bins_used[BIN_W-1:0];
               r.opened_new_bin = 1'b1;
            end else begin
               r.table_overflow = 1'b1;
            end
         end
         foreach (bin_differs[b]) bin_differs[b] = 1'b0;
         geno_pos = 0;
      end
   endtask

   // called at a rising edge; returns at the edge where the word is taken
   task automatic push_word(input logic [3:0] g, input bit l, input bit f,
                            input bit known, input bin_rsp_type typed);
      bit taken;
      bit has_rsp;
      bin_rsp_type r;
      req.valid            <= 1'b1;
      req.genotype         <= g;
      req.last_of_marker   <= l;
      req.first_of_dataset <= f;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end
      bin_word(g, l, f, has_rsp, r);
      if (has_rsp) bin_q.insert(bin_q.size(), known ? typed : r);
   endtask

   task automatic word_gap();
      int n;
      int r;
      r = $urandom_range(0, 99);
      n = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (n > 0) begin
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // block idle: every response in and the search pipeline empty
   task automatic wait_idle();
      req.valid <= 1'b0;
      wait (bin_q.size() == 0);
      @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_mode(input bit v);
      bit taken;
      csr.valid <= 1'b1;
      csr.data  <= v;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr.ready;
         @(posedge clock);
      end
      csr.valid <= 1'b0;
      exact_cfg = v;
   endtask

   // response side: random stalls plus the long hold-off
   initial begin
      int stall;
      int r;
      stall = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 8) stall = $urandom_range(1, 3);
            else if (r < 10) stall = $urandom_range(10, 40);
         end
      end
   end

   initial begin
      hold_rsp = 1'b0;
      wait (hold_go);
      hold_rsp = 1'b1;
      repeat (700) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(negedge clock) begin
      bin_rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (bin_q.size() == 0) begin
            $error("response word with nothing expected: bin %0d", rsp.bin_number);
            errors++;
         end else begin
            e = bin_q.pop_front();
            if (rsp.bin_number !== e.bin_number) begin
               $error("bin_number: expected %0d, got %0d", e.bin_number, rsp.bin_number);
               errors++;
            end
            if (rsp.opened_new_bin !== e.opened_new_bin) begin
               $error("opened_new_bin: expected %0d, got %0d",
                      e.opened_new_bin, rsp.opened_new_bin);
               errors++;
            end
            if (rsp.table_overflow !== e.table_overflow) begin
               $error("table_overflow: expected %0d, got %0d",
                      e.table_overflow, rsp.table_overflow);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type rows [18];
      logic [3:0] prev [32][MAX_INDIVIDUALS];
      int n_prev;
      int words;
      int len;
      int n_markers;
      int src;
      bit first;
      bit abort;
      bin_rsp_type none;
      logic [3:0] g;

      errors    = 0;
      cycles    = 0;
      hold_go   = 1'b0;
      exact_cfg = 1'b1;
      geno_pos  = 0;
      bins_used = 0;
      foreach (bin_differs[b]) bin_differs[b] = 1'b0;
      none = '0;

      reset                <= 1'b1;
      req.valid            <= 1'b0;
      req.genotype         <= '0;
      req.last_of_marker   <= 1'b0;
      req.first_of_dataset <= 1'b0;
      csr.valid            <= 1'b0;
      csr.data             <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         '{ROW_WORD, 4'd15, 0, 1, 0, '0},
         '{ROW_WORD, 4'd0,  1, 0, 1, '{7'd1, 1'b1, 1'b0}},  // empty table
         '{ROW_WORD, 4'd15, 0, 0, 0, '0},
         '{ROW_WORD, 4'd0,  1, 0, 1, '{7'd1, 1'b0, 1'b0}},
         '{ROW_WORD, 4'd15, 0, 0, 0, '0},
         '{ROW_WORD, 4'd3,  1, 0, 1, '{7'd2, 1'b1, 1'b0}},
         '{ROW_CSR,  4'd0,  0, 0, 0, '0},                   // wildcard on missing
         '{ROW_WORD, 4'd0,  0, 0, 0, '0},
         '{ROW_WORD, 4'd3,  1, 0, 1, '{7'd2, 1'b0, 1'b0}},  // newest wins
         '{ROW_WORD, 4'd15, 0, 0, 0, '0},
         '{ROW_WORD, 4'd0,  1, 0, 1, '{7'd2, 1'b0, 1'b0}},
         '{ROW_WORD, 4'd7,  0, 0, 0, '0},
         '{ROW_CSR,  4'd1,  0, 0, 0, '0},                   // mode change mid-marker
         '{ROW_WORD, 4'd3,  1, 0, 0, '0},
         '{ROW_WORD, 4'd9,  1, 1, 1, '{7'd1, 1'b1, 1'b0}},
         '{ROW_WORD, 4'd9,  1, 0, 1, '{7'd1, 1'b0, 1'b0}},
         '{ROW_WORD, 4'd0,  1, 0, 1, '{7'd2, 1'b1, 1'b0}},
         '{ROW_WORD, 4'd6,  1, 0, 0, '0}
      };
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_mode(rows[i].geno[0]);
         end else begin
            word_gap();
            push_word(rows[i].geno, rows[i].last, rows[i].first,
                      rows[i].known, rows[i].rsp);
         end
      end

      // overflow: 70 distinct two-word markers
      wait_idle();
      write_mode(1'b0);
      for (int i = 0; i < 70; i++) begin
         word_gap();
         push_word(4'(1 + i % 15), 1'b0, i == 0, 1'b0, none);
         push_word(4'(1 + i / 15), 1'b1, 1'b0, 1'b0, none);
      end

      // marker longer than the buffer
      for (int p = 0; p < MAX_INDIVIDUALS + 4; p++) begin
         push_word(4'(p % 16), p == MAX_INDIVIDUALS + 3, p == 0, 1'b0, none);
      end

      // random datasets
      words = 0;
      while (words < RAND_WORDS) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_mode($urandom_range(0, 1));
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
         n_markers = $urandom_range(3, 30);
         n_prev = 0;
         first = 1'b1;
         abort = 1'b0;
         for (int m = 0; m < n_markers && !abort; m++) begin
            src = (n_prev > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n_prev - 1) : -1;
            for (int p = 0; p < len && !abort; p++) begin
               if (src < 0 || $urandom_range(0, 5) == 0)
                  g = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
               else
                  g = prev[src][p];
               if (n_prev < 32) prev[n_prev][p] = g;
               // broken marker: a new dataset starts part way through
               if (!first && p < len - 1 && $urandom_range(0, 99) < 3) abort = 1'b1;
               word_gap();
               push_word(g, abort ? 1'b0 : (p == len - 1), first, 1'b0, none);
               first = 1'b0;
               words++;
               if (words == 100) hold_go = 1'b1;
            end
            if (n_prev < 32) n_prev++;
         end
         if (words > 200 && words < 250) begin
            // sender waits for every response before going on
            req.valid <= 1'b0;
            wait (bin_q.size() == 0);
            @(posedge clock);
         end
      end

      req.valid <= 1'b0;
      wait (bin_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
rtl/core/gvb_pkg.sv
rtl/core/gvb_if.sv
rtl/core/gvb_cell.sv
rtl/core/genotype_vector_binning.sv
tb/sv/tb_genotype_vector_binning.sv
